// ===== rtl/cpa_pkg.sv =====
// ============================================================================
// cpa_pkg: shared types and constants of the contiguous page allocator
// Widths, command and status codes, register indexes and the structs that
// join the controller and the datapath.
// ============================================================================
package cpa_pkg;

    // Map geometry.
    localparam int MAX_PAGES  = 1024;
    localparam int PAGE_BYTES = 4096;

    // Field widths.
    localparam int CMD_W      = 2;
    localparam int CNT_W      = 11;
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Map index and counter widths.
    localparam int IDX_W = $clog2(MAX_PAGES);
    localparam int PTR_W = $clog2(MAX_PAGES + 1);
    localparam int CMP_W = (PTR_W > CNT_W) ? PTR_W : CNT_W;
    localparam int END_W = CMP_W + 1;

    // Stream word widths.
    localparam int IN_FIELDS_W = CNT_W + ADDR_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ADDR_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MANAGED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 2'd2;

    // Configuration reset values.
    localparam logic [CNT_W-1:0]  MANAGED_RESET  = 11'd1024;
    localparam logic [CNT_W-1:0]  RESERVED_RESET = 11'd1;
    localparam logic [ADDR_W-1:0] BASE_RESET     = 32'h8000_0000;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        DP_NONE,
        DP_LOAD,
        DP_SWEEP_ZERO,
        DP_SWEEP_INIT,
        DP_ASCAN,
        DP_AWRITE,
        DP_FSCAN,
        DP_FCLEAR
    } dp_op_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [CNT_W-1:0]  managed;
        logic [CNT_W-1:0]  reserved;
        logic [ADDR_W-1:0] base;
    } cfg_t;

    // Status returned from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             alloc_bad;
        logic             sweep_last;
        logic             found;
        logic             exhausted;
        logic             write_last;
    } dp_stat_t;

    // Finished result offered by the controller.
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic                use_addr;
    } res_t;

endpackage

// ===== rtl/cpa_datapath.sv =====
// ============================================================================
// cpa_datapath: page map memories, scan counters and address tracking
// Holds the busy, start mark and run length memories and carries out the
// sweeps, scans and write passes that the controller selects word by word.
// ============================================================================
module cpa_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cpa_pkg::dp_op_t              op,
    input  cpa_pkg::cfg_t                cfg,
    input  logic [cpa_pkg::CMD_W-1:0]    in_cmd,
    input  logic [cpa_pkg::CNT_W-1:0]    in_page_count,
    input  logic [cpa_pkg::ADDR_W-1:0]   in_free_address,
    output cpa_pkg::dp_stat_t            stat,
    output logic [cpa_pkg::ADDR_W-1:0]   run_address
);
    import cpa_pkg::*;

    // Page map storage.
    logic             busy_mem [0:MAX_PAGES-1];
    logic             mark_mem [0:MAX_PAGES-1];
    logic [CNT_W-1:0] len_mem  [0:MAX_PAGES-1];

    // Control registers.
    logic [CMP_W-1:0]  idx_reg, idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [CMP_W-1:0]  run_reg, run_next;
    logic [CMP_W-1:0]  wptr_reg, wptr_next;

    // Payload registers.
    logic [CMD_W-1:0]  cmd_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] faddr_reg;
    logic [ADDR_W-1:0] iaddr_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [IDX_W-1:0]  start_reg;
    logic [ADDR_W-1:0] start_addr_reg;
    logic              busy_q_reg;
    logic              mark_q_reg;
    logic [CNT_W-1:0]  len_q_reg;

    // Derived limits and flags.
    logic [CMP_W-1:0]  n_eff;
    logic [CMP_W-1:0]  r_eff;
    logic [CMP_W-1:0]  managed_ext;
    logic [CMP_W-1:0]  reserved_ext;
    logic [CMP_W-1:0]  count_ext;
    logic              issue;
    logic              alloc_hit;
    logic              free_hit;
    logic              new_run;
    logic              at_start;
    logic              awrite_last;
    logic              fclear_last;

    // Memory port controls.
    logic [IDX_W-1:0]  wr_addr;
    logic              busy_we;
    logic              busy_wd;
    logic              mark_we;
    logic              mark_wd;
    logic              len_we;
    logic [IDX_W-1:0]  len_ra;

    // Effective managed and reserved counts.
    assign managed_ext  = CMP_W'(cfg.managed);
    assign reserved_ext = CMP_W'(cfg.reserved);
    assign count_ext    = CMP_W'(count_reg);
    assign n_eff = (managed_ext > CMP_W'(MAX_PAGES)) ? CMP_W'(MAX_PAGES) : managed_ext;
    assign r_eff = (reserved_ext > n_eff) ? n_eff : reserved_ext;

    // Scan issue and evaluation of the registered read word.
    assign issue     = ((op == DP_ASCAN) || (op == DP_FSCAN)) && (idx_reg < n_eff);
    assign new_run   = rd_vld_reg && !busy_q_reg && (run_reg == '0);
    assign alloc_hit = (op == DP_ASCAN) && rd_vld_reg && !busy_q_reg
                       && ((run_reg + CMP_W'(1)) == count_ext);
    assign free_hit  = (op == DP_FSCAN) && rd_vld_reg && mark_q_reg
                       && (rd_addr_reg == faddr_reg);

    // End conditions of the write passes.
    assign at_start    = (wptr_reg[IDX_W-1:0] == start_reg);
    assign awrite_last = ((wptr_reg + CMP_W'(1)) == (CMP_W'(start_reg) + count_ext));
    assign fclear_last = ((END_W'(wptr_reg) + END_W'(1))
                          == (END_W'(start_reg) + END_W'(len_q_reg)))
                         || (wptr_reg == CMP_W'(MAX_PAGES - 1));

    // Status towards the controller.
    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.alloc_bad  = (count_reg == '0) || (count_ext > n_eff);
        stat.sweep_last = (idx_reg == CMP_W'(MAX_PAGES - 1));
        stat.found      = alloc_hit || free_hit;
        stat.exhausted  = !rd_vld_reg && !(idx_reg < n_eff);
        stat.write_last = (op == DP_AWRITE) ? awrite_last : fclear_last;
    end

    assign run_address = start_addr_reg;

    // Memory write selection for the current operation.
    always_comb
    begin
        wr_addr = wptr_reg[IDX_W-1:0];
        busy_we = 1'b0;
        busy_wd = 1'b0;
        mark_we = 1'b0;
        mark_wd = 1'b0;
        len_we  = 1'b0;
        unique case (op)
            DP_SWEEP_ZERO:
            begin
                wr_addr = idx_reg[IDX_W-1:0];
                busy_we = 1'b1;
                mark_we = 1'b1;
            end
            DP_SWEEP_INIT:
            begin
                wr_addr = idx_reg[IDX_W-1:0];
                busy_we = 1'b1;
                busy_wd = (idx_reg < r_eff);
                mark_we = 1'b1;
            end
            DP_AWRITE:
            begin
                busy_we = 1'b1;
                busy_wd = 1'b1;
                mark_we = 1'b1;
                mark_wd = at_start;
                len_we  = at_start;
            end
            DP_FCLEAR:
            begin
                busy_we = 1'b1;
                mark_we = at_start;
            end
            default:
            begin
                busy_we = 1'b0;
            end
        endcase
    end

    // The length is read at the word under test during a free scan.
    assign len_ra = (op == DP_FSCAN) ? rd_idx_reg : start_reg;

    // Page map memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (busy_we)
        begin
            busy_mem[wr_addr] <= busy_wd;
        end
        if (mark_we)
        begin
            mark_mem[wr_addr] <= mark_wd;
        end
        if (len_we)
        begin
            len_mem[wr_addr] <= count_reg;
        end
        busy_q_reg <= busy_mem[idx_reg[IDX_W-1:0]];
        mark_q_reg <= mark_mem[idx_reg[IDX_W-1:0]];
        len_q_reg  <= len_mem[len_ra];
    end

    // Next state of the counters.
    always_comb
    begin
        idx_next    = idx_reg;
        rd_vld_next = rd_vld_reg;
        run_next    = run_reg;
        wptr_next   = wptr_reg;
        unique case (op)
            DP_LOAD:
            begin
                idx_next    = '0;
                rd_vld_next = 1'b0;
                run_next    = '0;
            end
            DP_SWEEP_ZERO, DP_SWEEP_INIT:
            begin
                idx_next = idx_reg + CMP_W'(1);
            end
            DP_ASCAN:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + CMP_W'(1);
                end
                rd_vld_next = issue;
                if (rd_vld_reg)
                begin
                    run_next = busy_q_reg ? '0 : run_reg + CMP_W'(1);
                end
                if (new_run)
                begin
                    wptr_next = CMP_W'(rd_idx_reg);
                end
            end
            DP_FSCAN:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + CMP_W'(1);
                end
                rd_vld_next = issue;
                if (free_hit)
                begin
                    wptr_next = CMP_W'(rd_idx_reg);
                end
            end
            DP_AWRITE, DP_FCLEAR:
            begin
                wptr_next = wptr_reg + CMP_W'(1);
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    // Counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            run_reg    <= '0;
            wptr_reg   <= '0;
        end
        else
        begin
            idx_reg    <= idx_next;
            rd_vld_reg <= rd_vld_next;
            run_reg    <= run_next;
            wptr_reg   <= wptr_next;
        end
    end

    // Item fields, scan addresses and the run found.
    always_ff @(posedge clk)
    begin
        if (op == DP_LOAD)
        begin
            cmd_reg   <= in_cmd;
            count_reg <= in_page_count;
            faddr_reg <= in_free_address;
            iaddr_reg <= cfg.base;
        end
        else if (issue)
        begin
            iaddr_reg <= iaddr_reg + ADDR_W'(PAGE_BYTES);
        end
        rd_idx_reg  <= idx_reg[IDX_W-1:0];
        rd_addr_reg <= iaddr_reg;
        if (((op == DP_ASCAN) && new_run) || free_hit)
        begin
            start_reg      <= rd_idx_reg;
            start_addr_reg <= rd_addr_reg;
        end
    end

    // A write pass never runs past the end of the map.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((op == DP_AWRITE) || (op == DP_FCLEAR)) |-> (wptr_reg < CMP_W'(MAX_PAGES)))
        else $error("write pointer beyond the page map");

    // A hit is only ever reported for a word that was really read.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.found |-> rd_vld_reg)
        else $error("scan hit without read data");

endmodule

// ===== rtl/cpa_ctrl.sv =====
// ============================================================================
// cpa_ctrl: command sequencer of the page allocator
// Steps through the reset clearing pass, decode, sweeps, scans and write
// passes, and holds the result until the output register takes it.
// ============================================================================
module cpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_free,
    input  cpa_pkg::dp_stat_t   stat,
    output cpa_pkg::dp_op_t     op,
    output cpa_pkg::res_t       res
);
    import cpa_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_DECODE = 9'b000000100,
        ST_INIT   = 9'b000001000,
        ST_ASCAN  = 9'b000010000,
        ST_AWRITE = 9'b000100000,
        ST_FSCAN  = 9'b001000000,
        ST_FCLEAR = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                use_addr_reg, use_addr_next;

    // Next state, datapath operation and result code.
    always_comb
    begin
        state_next    = state_reg;
        status_next   = status_reg;
        use_addr_next = use_addr_reg;
        op            = DP_NONE;
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                op = DP_SWEEP_ZERO;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op            = DP_LOAD;
                    status_next   = STATUS_OK;
                    use_addr_next = 1'b0;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.cmd)
                    CMD_INIT:
                    begin
                        state_next = ST_INIT;
                    end
                    CMD_ALLOC:
                    begin
                        if (stat.alloc_bad)
                        begin
                            status_next = STATUS_NO_SPACE;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_ASCAN;
                        end
                    end
                    CMD_FREE:
                    begin
                        state_next = ST_FSCAN;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_INIT:
            begin
                op = DP_SWEEP_INIT;
                if (stat.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ASCAN:
            begin
                op = DP_ASCAN;
                if (stat.found)
                begin
                    state_next = ST_AWRITE;
                end
                else if (stat.exhausted)
                begin
                    status_next = STATUS_NO_SPACE;
                    state_next  = ST_DONE;
                end
            end
            ST_AWRITE:
            begin
                op = DP_AWRITE;
                if (stat.write_last)
                begin
                    use_addr_next = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_FSCAN:
            begin
                op = DP_FSCAN;
                if (stat.found)
                begin
                    state_next = ST_FCLEAR;
                end
                else if (stat.exhausted)
                begin
                    status_next = STATUS_NOT_FOUND;
                    state_next  = ST_DONE;
                end
            end
            ST_FCLEAR:
            begin
                op = DP_FCLEAR;
                if (stat.write_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            status_reg   <= STATUS_OK;
            use_addr_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            status_reg   <= status_next;
            use_addr_reg <= use_addr_next;
        end
    end

    assign res.valid    = (state_reg == ST_DONE);
    assign res.status   = status_reg;
    assign res.use_addr = use_addr_reg;

    // A finished result is handed on as soon as there is room for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && out_free) |=> (state_reg == ST_IDLE))
        else $error("result not released to the output register");

    // A waiting result keeps its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !out_free) |=> (res.valid && $stable(status_reg)))
        else $error("waiting result changed");

    // The clearing pass after reset takes no item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("item taken during the clearing pass");

endmodule

// ===== rtl/contiguous_page_allocator_core.sv =====
// ============================================================================
// contiguous_page_allocator_core: first-fit contiguous page allocator
// Keeps a page map and serves init, allocate and free commands, one at a
// time, with a configuration write port and a registered result stage.
// ============================================================================
//
// Channel   Direction  Word contents
// s_axis    in         tuser: cmd; tdata: page_count, free_address
// m_axis    out        tuser: status; tdata: run_address
// cfg       in         cfg_index selects the register, cfg_data its value
//
// An init sweeps all MAX_PAGES map words. An allocate or a free is paced
// by the map scan, one map word per cycle through the memories.
// After reset a clearing pass over all MAX_PAGES (1024) map words runs
// before the first item is taken; configuration writes are always taken.
// A result waits in the output register while the next item is processed;
// that item's result is held back until the register is free.
module contiguous_page_allocator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [10:0] page_count, [42:11] free_address, upper bits zero
    input  logic [cpa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] cmd
    input  logic [cpa_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] run_address
    output logic [cpa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic [cpa_pkg::STATUS_W-1:0]      m_axis_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cpa_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cpa_pkg::*;

    cfg_t               cfg_reg;
    dp_op_t             op;
    dp_stat_t           stat;
    res_t               res;
    logic [ADDR_W-1:0]  run_address;
    logic               out_free;
    logic               out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ADDR_W-1:0]  out_addr_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.managed  <= MANAGED_RESET;
            cfg_reg.reserved <= RESERVED_RESET;
            cfg_reg.base     <= BASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MANAGED:  cfg_reg.managed  <= cfg_data[CNT_W-1:0];
                CFG_RESERVED: cfg_reg.reserved <= cfg_data[CNT_W-1:0];
                CFG_BASE:     cfg_reg.base     <= cfg_data[ADDR_W-1:0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // Sequencer.
    cpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .stat     (stat),
        .op       (op),
        .res      (res)
    );

    // Page map and scan datapath.
    cpa_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (op),
        .cfg             (cfg_reg),
        .in_cmd          (s_axis_tuser),
        .in_page_count   (s_axis_tdata[CNT_W-1:0]),
        .in_free_address (s_axis_tdata[IN_FIELDS_W-1:CNT_W]),
        .stat            (stat),
        .run_address     (run_address)
    );

    // Output register.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && out_free)
        begin
            out_status_reg <= res.status;
            out_addr_reg   <= res.use_addr ? run_address : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_addr_reg;
    assign m_axis_tuser  = out_status_reg;

    // Once an item is taken, no further item is taken until it is finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item taken while one is in progress");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the contiguous page allocator core
// Drives init, allocate and free words into the stream input and keeps its
// own copy of the page map to predict each status and run address. Results
// are checked in order. The map configuration is changed between phases,
// and both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;

    import cpa_pkg::*;

    // Codes that the package leaves unnamed, a hold length and the pad width.
    localparam logic [CMD_W-1:0]     CMD_NOP    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
    localparam int                   LONG_HOLD  = 4000;
    localparam int                   PAD_W      = IN_TDATA_W - IN_FIELDS_W;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CNT_W-1:0]  page_count;
        logic [ADDR_W-1:0] free_address;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   run_address;
    } outcome_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]       s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Predicted map and configuration.
    bit                busy_bit [MAX_PAGES];
    bit                run_head [MAX_PAGES];
    logic [CNT_W-1:0]  head_length [MAX_PAGES];
    logic [CNT_W-1:0]  managed_reg = MANAGED_RESET;
    logic [CNT_W-1:0]  reserved_reg = RESERVED_RESET;
    logic [ADDR_W-1:0] base_reg = BASE_RESET;
    logic [ADDR_W-1:0] live_runs [$];

    request_t pending_requests [$];
    outcome_t expected_results [$];
    int       queued_count = 0;
    int       accepted_count = 0;
    int       error_count = 0;
    bit       in_word_taken = 1'b0;
    bit       quiet_tail = 1'b0;
    int       send_gap = 0;
    int       recv_gap = 0;
    int       hold_requests = 0;
    int       holds_served = 0;
    int       hold_left = 0;

    contiguous_page_allocator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("testbench: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Page map prediction
    // ------------------------------------------------------------------

    function automatic int unsigned pages_in_use();
        return (managed_reg > MAX_PAGES) ? MAX_PAGES : managed_reg;
    endfunction

    function automatic logic [ADDR_W-1:0] page_address(int unsigned idx);
        return base_reg + ADDR_W'(idx * PAGE_BYTES);
    endfunction

    // Applies one command to the map and returns the result it must give.
    function automatic outcome_t serve_command(logic [CMD_W-1:0] cmd,
                                               logic [CNT_W-1:0] count,
                                               logic [ADDR_W-1:0] where);
        outcome_t    res;
        int unsigned span;
        int unsigned keep;
        int unsigned run;
        int unsigned first;
        int unsigned k;
        bit          hit;
        res.status      = STATUS_OK;
        res.run_address = '0;
        span = pages_in_use();
        hit  = 1'b0;
        run  = 0;
        first = 0;
        case (cmd)
            CMD_INIT:
            begin
                keep = (reserved_reg > span) ? span : reserved_reg;
                for (int i = 0; i < MAX_PAGES; i++)
                begin
                    busy_bit[i] = (i < keep);
                    run_head[i] = 1'b0;
                end
                live_runs.delete();
            end
            CMD_ALLOC:
            begin
                // First fit: lowest free stretch that reaches the count.
                if (count != 0 && count <= span)
                begin
                    for (int i = 0; i < span; i++)
                    begin
                        if (busy_bit[i])
                            run = 0;
                        else
                        begin
                            if (run == 0)
                                first = i;
                            run++;
                            if (run == count)
                            begin
                                hit = 1'b1;
                                break;
                            end
                        end
                    end
                end
                if (!hit)
                    res.status = STATUS_NO_SPACE;
                else
                begin
                    // Stale start marks inside the new run are wiped.
                    for (int i = first; i < first + count; i++)
                    begin
                        busy_bit[i] = 1'b1;
                        run_head[i] = 1'b0;
                    end
                    run_head[first]    = 1'b1;
                    head_length[first] = count;
                    res.run_address    = page_address(first);
                    live_runs.push_back(res.run_address);
                end
            end
            CMD_FREE:
            begin
                res.status = STATUS_NOT_FOUND;
                for (int i = 0; i < span; i++)
                begin
                    if (run_head[i] && page_address(i) == where)
                    begin
                        for (k = 0; k < head_length[i] && i + k < MAX_PAGES; k++)
                            busy_bit[i + k] = 1'b0;
                        run_head[i] = 1'b0;
                        res.status  = STATUS_OK;
                        for (int j = 0; j < live_runs.size(); j++)
                        begin
                            if (live_runs[j] == where)
                            begin
                                live_runs.delete(j);
                                break;
                            end
                        end
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] want,
                                   input logic [ADDR_W-1:0] got);
        if (error_count < 100)
            $display("%0t ns: %s: expected %0h, got %0h", $time, what, want, got);
        error_count++;
    endtask

    // Watch all three channels at the rising edge.
    always @(posedge clk)
    begin : watch_ports
        outcome_t want;
        in_word_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MANAGED:  managed_reg  = cfg_data[CNT_W-1:0];
                    CFG_RESERVED: reserved_reg = cfg_data[CNT_W-1:0];
                    CFG_BASE:     base_reg     = cfg_data[ADDR_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_word_taken = 1'b1;
                want = serve_command(s_axis_tuser, s_axis_tdata[CNT_W-1:0],
                                     s_axis_tdata[CNT_W +: ADDR_W]);
                expected_results.push_back(want);
                accepted_count++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result word with nothing pending", '0, m_axis_tdata);
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", ADDR_W'(want.status), ADDR_W'(m_axis_tuser));
                    if (m_axis_tdata !== want.run_address)
                        report_mismatch("run address", want.run_address, m_axis_tdata);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stream drivers, changed at the falling edge
    // ------------------------------------------------------------------

    // Input side: keep the word until taken, then offer the next one.
    always @(negedge clk)
    begin : drive_requests
        request_t next_req;
        logic     offer;
        if (rst_n)
        begin
            offer = s_axis_tvalid && !in_word_taken;
            if (!offer)
            begin
                if (send_gap > 0 && !quiet_tail)
                    send_gap--;
                else if (pending_requests.size() > 0)
                begin
                    next_req = pending_requests.pop_front();
                    s_axis_tdata <= {{PAD_W{1'b0}}, next_req.free_address,
                                     next_req.page_count};
                    s_axis_tuser <= next_req.cmd;
                    offer = 1'b1;
                    if (!quiet_tail && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 19);
                end
            end
            s_axis_tvalid <= offer;
        end
    end

    // Output side: random stall bursts plus the occasional long hold-off.
    always @(negedge clk)
    begin : drive_result_ready
        if (rst_n)
        begin
            if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (recv_gap > 0 && !quiet_tail)
            begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(1, 19) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [CNT_W-1:0] count,
                                 input logic [ADDR_W-1:0] where);
        request_t r;
        r.cmd          = cmd;
        r.page_count   = count;
        r.free_address = where;
        pending_requests.push_back(r);
        queued_count++;
    endtask

    // Wait until every queued word is taken and every result is back.
    task automatic settle();
        while (accepted_count != queued_count || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // The page counts go out with junk above bit 10, which must be dropped.
    task automatic setup_map(input logic [CNT_W-1:0] managed, input logic [CNT_W-1:0] reserved,
                             input logic [ADDR_W-1:0] base);
        write_register(CFG_MANAGED, {(CFG_DATA_W - CNT_W)'($urandom), managed});
        write_register(CFG_RESERVED, {(CFG_DATA_W - CNT_W)'($urandom), reserved});
        write_register(CFG_BASE, base);
    endtask

    // Mostly sensible allocates and frees of live runs, with some noise.
    function automatic request_t random_request();
        request_t    r;
        int unsigned span;
        int unsigned top;
        int unsigned pick;
        span = pages_in_use();
        r.cmd          = CMD_ALLOC;
        r.page_count   = CNT_W'($urandom_range(0, 2047));
        r.free_address = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            r.cmd = CMD_INIT;
        else if (pick < 5)
            r.cmd = CMD_NOP;
        else if (pick < 55)
        begin
            top = (span < 8) ? span : span / 4;
            if (top == 0)
                top = 1;
            if ($urandom_range(0, 9) != 0)
                r.page_count = CNT_W'($urandom_range(1, top));
            else
            begin
                case ($urandom_range(0, 3))
                    0: r.page_count = '0;
                    1: r.page_count = CNT_W'(span);
                    2: r.page_count = CNT_W'(span + 1);
                    default:
                    begin
                    end
                endcase
            end
        end
        else
        begin
            r.cmd = CMD_FREE;
            if (live_runs.size() > 0 && $urandom_range(0, 4) != 0)
                r.free_address = live_runs[$urandom_range(0, live_runs.size() - 1)];
            else if ($urandom_range(0, 1) == 0)
                r.free_address = page_address($urandom_range(0, span));
        end
        return r;
    endfunction

    task automatic random_phase(input logic [CNT_W-1:0] managed,
                                input logic [CNT_W-1:0] reserved,
                                input logic [ADDR_W-1:0] base, input int count,
                                input bit long_hold);
        settle();
        setup_map(managed, reserved, base);
        if (long_hold)
            hold_requests++;
        queue_request(CMD_INIT, CNT_W'($urandom), $urandom);
        for (int n = 1; n < count; n++)
        begin
            while (pending_requests.size() >= 4)
                @(posedge clk);
            pending_requests.push_back(random_request());
            queued_count++;
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration, map still all free before any init.
        queue_request(CMD_ALLOC, 11'd0, $urandom);
        queue_request(CMD_ALLOC, 11'd1, $urandom);
        queue_request(CMD_FREE, CNT_W'($urandom), BASE_RESET);
        queue_request(CMD_FREE, CNT_W'($urandom), BASE_RESET);
        queue_request(CMD_NOP, CNT_W'($urandom), $urandom);
        queue_request(CMD_INIT, CNT_W'($urandom), $urandom);
        queue_request(CMD_ALLOC, 11'd1024, $urandom);
        queue_request(CMD_ALLOC, 11'd2047, $urandom);
        queue_request(CMD_ALLOC, 11'd1023, $urandom);
        queue_request(CMD_FREE, CNT_W'($urandom), BASE_RESET + PAGE_BYTES);
        queue_request(CMD_FREE, CNT_W'($urandom), 32'hFFFF_FFFF);

        // Both page counts above their limits: the whole map is reserved.
        settle();
        setup_map(11'd2047, 11'd2047, 32'hFFFF_F000);
        queue_request(CMD_INIT, CNT_W'($urandom), $urandom);
        queue_request(CMD_ALLOC, 11'd1, $urandom);

        // No reserved pages; the second run's address wraps past the top.
        settle();
        setup_map(11'd2047, 11'd0, 32'hFFFF_F000);
        queue_request(CMD_INIT, CNT_W'($urandom), $urandom);
        queue_request(CMD_ALLOC, 11'd1, $urandom);
        queue_request(CMD_ALLOC, 11'd2, $urandom);
        queue_request(CMD_FREE, CNT_W'($urandom), 32'h0000_0000);

        // No managed pages: the live run at page zero is out of reach.
        settle();
        setup_map(11'd0, 11'd0, 32'hFFFF_F000);
        write_register(CFG_SPARE, $urandom);
        queue_request(CMD_ALLOC, 11'd1, $urandom);
        queue_request(CMD_FREE, CNT_W'($urandom), 32'hFFFF_F000);
        queue_request(CMD_INIT, CNT_W'($urandom), $urandom);

        // Small map: first fit, a stretch too short and a count too large.
        settle();
        setup_map(11'd8, 11'd2, 32'h1000_0000);
        queue_request(CMD_INIT, CNT_W'($urandom), $urandom);
        queue_request(CMD_ALLOC, 11'd4, $urandom);
        queue_request(CMD_ALLOC, 11'd3, $urandom);
        queue_request(CMD_ALLOC, 11'd2, $urandom);
        queue_request(CMD_ALLOC, 11'd9, $urandom);

        // Shrinking the map hides the run at page six until it grows again.
        settle();
        setup_map(11'd4, 11'd2, 32'h1000_0000);
        queue_request(CMD_FREE, CNT_W'($urandom), 32'h1000_6000);
        settle();
        setup_map(11'd8, 11'd2, 32'h1000_0000);
        queue_request(CMD_FREE, CNT_W'($urandom), 32'h1000_6000);

        // Random phases over a spread of map sizes and bases.
        random_phase(11'd32, 11'd0, $urandom & 32'hFFFF_F000, 90, 1'b1);
        random_phase(11'd64, 11'd5, 32'hFFFE_0000, 90, 1'b0);
        random_phase(11'd1, 11'd0, $urandom & 32'hFFFF_F000, 40, 1'b0);
        random_phase(11'd1024, 11'd1000, 32'h8000_0000, 30, 1'b0);
        random_phase(11'd16, 11'd3, $urandom & 32'hFFFF_F000, 100, 1'b0);
        random_phase(11'd128, 11'd0, 32'h0000_0000, 100, 1'b0);
        settle();
        quiet_tail = 1'b1;
        random_phase(11'd48, 11'd2, $urandom & 32'hFFFF_F000, 100, 1'b0);

        // Let any stray result words show up before the verdict.
        settle();
        repeat (2100) @(posedge clk);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cpa_pkg.sv
rtl/cpa_datapath.sv
rtl/cpa_ctrl.sv
rtl/contiguous_page_allocator_core.sv
tb/testbench.sv
